FILE: sv/nrmc_pkg.sv
`timescale 1ns / 1ps
package nrmc_pkg;

  localparam int MAX_NEIGHBOURS     = 4;
  localparam int REPORT_MIN_MATCHES = 2;
  localparam int CORDIC_STEPS       = 16;

  localparam int COUNT_CAP = (MAX_NEIGHBOURS > 7) ? 7 : MAX_NEIGHBOURS;

  localparam int LAT_W  = 18;
  localparam int LON_W  = 19;
  localparam int MAG_W  = 12;
  localparam int DIST_W = 19;
  localparam int CNT_W  = 3;

  // CORDIC datapath widths
  localparam int XY_W  = 34;
  localparam int Z_W   = 26;
  localparam int IDX_W = 5;

  localparam int unsigned CORDIC_GAIN  = 652032874;
  localparam int unsigned KM16_PER_DEG = 7286920;

  // angle reduction, units 1/1024 degree
  localparam int FULL_TURN    = 368640;
  localparam int HALF_TURN    = 184320;
  localparam int QUARTER_TURN = 92160;

  localparam logic [1:0] REG_TRIGGER   = 2'd0;
  localparam logic [1:0] REG_DISTANCE  = 2'd1;
  localparam logic [1:0] REG_TOLERANCE = 2'd2;

  typedef struct packed {
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [Z_W-1:0]  z;
  } cordic_t;

  typedef logic signed [Z_W-1:0] atan_arr_t [32];

  localparam atan_arr_t ATAN_TAB = '{
    26'sd2949120, 26'sd1740967, 26'sd919879, 26'sd466945,
    26'sd234379,  26'sd117304,  26'sd58666,  26'sd29335,
    26'sd14668,   26'sd7334,    26'sd3667,   26'sd1833,
    26'sd917,     26'sd458,     26'sd229,    26'sd115,
    26'sd57,      26'sd29,      26'sd14,     26'sd7,
    26'sd4,       26'sd2,       26'sd1,      26'sd0,
    26'sd0, 26'sd0, 26'sd0, 26'sd0, 26'sd0, 26'sd0, 26'sd0, 26'sd0
  };

endpackage

FILE: sv/nrmc_if.sv
`timescale 1ns / 1ps
interface nrmc_in_if import nrmc_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [LAT_W-1:0] own_latitude;
  logic signed [LON_W-1:0] own_longitude;
  logic [MAG_W-1:0]        own_magnitude;
  logic signed [LAT_W-1:0] neighbour_latitude;
  logic signed [LON_W-1:0] neighbour_longitude;
  logic [MAG_W-1:0]        neighbour_magnitude;
  logic                    neighbour_triggered;
  logic                    last_neighbour;

  modport source (output valid, own_latitude, own_longitude, own_magnitude,
                  neighbour_latitude, neighbour_longitude, neighbour_magnitude,
                  neighbour_triggered, last_neighbour, input ready);
  modport sink (input valid, own_latitude, own_longitude, own_magnitude,
                neighbour_latitude, neighbour_longitude, neighbour_magnitude,
                neighbour_triggered, last_neighbour, output ready);
endinterface

interface nrmc_out_if import nrmc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             pair_matches;
  logic [CNT_W-1:0] match_total;
  logic             report_event;
  logic             group_done;

  modport source (output valid, pair_matches, match_total, report_event, group_done,
                  input ready);
  modport sink (input valid, pair_matches, match_total, report_event, group_done,
                output ready);
endinterface

FILE: sv/nrmc_cordic.sv
`timescale 1ns / 1ps
module nrmc_cordic import nrmc_pkg::*; (
  input  cordic_t          cur,
  input  logic [IDX_W-1:0] idx,
  input  logic             vec_mode,
  output cordic_t          nxt
);
  logic signed [XY_W-1:0] dx, dy;
  logic signed [Z_W-1:0]  ang;
  logic                   pos;

  assign dx  = cur.y >>> idx;
  assign dy  = cur.x >>> idx;
  assign ang = ATAN_TAB[idx];
  // rotation steers by the residual angle, vectoring by the sign of y
  assign pos = vec_mode ? cur.y[XY_W-1] : !cur.z[Z_W-1];

  always_comb begin
    if (pos) begin
      nxt.x = cur.x - dx;
      nxt.y = cur.y + dy;
      nxt.z = cur.z - ang;
    end else begin
      nxt.x = cur.x + dx;
      nxt.y = cur.y - dy;
      nxt.z = cur.z + ang;
    end
  end
endmodule

FILE: sv/neighbour_reading_match_counter.sv
`timescale 1ns / 1ps
// Neighbour reading match counter.
// in_ch carries one item: own and neighbour position and magnitude, the
// neighbour's trigger flag and the end-of-group mark. out_ch returns one
// result per item: pair match, running match count, report flag, group end.
// cfg_we/cfg_index/cfg_wdata write trigger magnitude (0), distance limit (1)
// and magnitude tolerance (2); write only while the block is idle.
// Each item passes through three sin/cos rotations and the arccos vectoring
// pass, which share one CORDIC stage; the square root runs one bit per cycle,
// and all products go through one 32x32 multiplier. in_ch.ready is high only
// while no item is in flight. The result sits in an output register; the
// next item is taken while it waits, and the block holds in its final state
// if the previous result has still not been taken. Reset clears the
// configuration registers, the match count and the output valid flag, and
// returns the sequencer to idle.
module neighbour_reading_match_counter import nrmc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  nrmc_in_if.sink           in_ch,
  nrmc_out_if.source        out_ch,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [DIST_W-1:0] cfg_wdata
);

  typedef enum logic [13:0] {
    S_IDLE  = 14'b00000000000001,
    S_INIT  = 14'b00000000000010,
    S_ROT   = 14'b00000000000100,
    S_MULSS = 14'b00000000001000,
    S_MULCC = 14'b00000000010000,
    S_MULCT = 14'b00000000100000,
    S_SUM   = 14'b00000001000000,
    S_SQ    = 14'b00000010000000,
    S_RINIT = 14'b00000100000000,
    S_ROOT  = 14'b00001000000000,
    S_VINIT = 14'b00010000000000,
    S_VEC   = 14'b00100000000000,
    S_SCALE = 14'b01000000000000,
    S_FIN   = 14'b10000000000000
  } state_t;

  state_t state_r, state_nxt;

  logic [MAG_W-1:0]  trig_r, tol_r;
  logic [DIST_W-1:0] dlim_r;

  logic signed [LAT_W-1:0] la1_r, la2_r;
  logic signed [LON_W-1:0] lo1_r, lo2_r;
  logic [MAG_W-1:0]        m1_r, m2_r;
  logic                    ntrig_r, last_r;

  logic [1:0]       sel_r;
  logic [IDX_W-1:0] cnt_r;
  logic             neg_r;
  cordic_t          cur_r, cstep;
  logic             vec_mode;

  logic signed [31:0] s1_r, c1_r, s2_r, c2_r, ct_r;
  logic signed [31:0] d_r;
  logic signed [33:0] acc_r;
  logic signed [63:0] prod_r;
  logic [63:0]        n_r, res_r;
  logic [CNT_W-1:0]   count_r;

  logic               out_valid_r, out_match_r, out_report_r, out_done_r;
  logic [CNT_W-1:0]   out_total_r;

  // shared multiplier
  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] mul_p;

  // angle reduction
  logic signed [20:0] ang, r0, r1, r2, r3, r4;
  logic               fold;

  logic signed [31:0] ynew, xnew;
  logic signed [34:0] dsum;
  logic [63:0]        bitv, trial;
  logic [5:0]         bsh;
  logic [47:0]        dprod;
  logic [DIST_W:0]    km_dist;
  logic [MAG_W-1:0]   mdiff;
  logic               same_pos, match;
  logic [CNT_W-1:0]   total;
  logic               fin_go;

  assign vec_mode = (state_r == S_VEC);

  nrmc_cordic u_cordic (
    .cur      (cur_r),
    .idx      (cnt_r),
    .vec_mode (vec_mode),
    .nxt      (cstep)
  );

  always_comb begin
    case (sel_r)
      2'd0:    ang = 21'(la1_r);
      2'd1:    ang = 21'(la2_r);
      default: ang = 21'(lo1_r) - 21'(lo2_r);
    endcase
    r0 = ang[20] ? ang + 21'(FULL_TURN) : ang;
    r1 = r0[20] ? r0 + 21'(FULL_TURN) : r0;
    r2 = (r1 >= 21'(FULL_TURN)) ? r1 - 21'(FULL_TURN) : r1;
    r3 = (r2 > 21'(HALF_TURN)) ? r2 - 21'(FULL_TURN) : r2;
    fold = 1'b0;
    r4 = r3;
    if (r3 > 21'(QUARTER_TURN)) begin
      r4 = r3 - 21'(HALF_TURN);
      fold = 1'b1;
    end else if (r3 < -21'(QUARTER_TURN)) begin
      r4 = r3 + 21'(HALF_TURN);
      fold = 1'b1;
    end
  end

  always_comb begin
    case (state_r)
      S_MULSS: begin
        mul_a = s1_r;
        mul_b = s2_r;
      end
      S_MULCC: begin
        mul_a = c1_r;
        mul_b = c2_r;
      end
      S_MULCT: begin
        mul_a = prod_r[61:30];
        mul_b = ct_r;
      end
      S_SQ: begin
        mul_a = d_r;
        mul_b = d_r;
      end
      default: begin
        mul_a = (cur_r.z < 0) ? 32'sd0 : 32'(cur_r.z);
        mul_b = 32'(KM16_PER_DEG);
      end
    endcase
  end
  assign mul_p = mul_a * mul_b;

  assign xnew = neg_r ? -cstep.x[31:0] : cstep.x[31:0];
  assign ynew = neg_r ? -cstep.y[31:0] : cstep.y[31:0];
  assign dsum = 35'(acc_r) + 35'($signed(prod_r[63:30]));

  assign bsh   = 6'd62 - {cnt_r, 1'b0};
  assign bitv  = 64'd1 << bsh;
  assign trial = res_r + bitv;

  assign dprod    = prod_r[47:0] + 48'(64'd1 << 27);
  assign same_pos = (la1_r == la2_r) && (lo1_r == lo2_r);
  assign km_dist  = same_pos ? '0 : dprod[47:28];
  assign mdiff    = (m1_r > m2_r) ? m1_r - m2_r : m2_r - m1_r;
  assign match    = ntrig_r && (km_dist < {1'b0, dlim_r}) && (mdiff < tol_r);
  assign total    = (match && count_r < CNT_W'(COUNT_CAP)) ? count_r + 1'b1 : count_r;
  assign fin_go   = !out_valid_r || out_ch.ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_ch.valid) state_nxt = S_INIT;
      S_INIT:  state_nxt = S_ROT;
      S_ROT: begin
        if (cnt_r == IDX_W'(CORDIC_STEPS - 1))
          state_nxt = (sel_r == 2'd2) ? S_MULSS : S_INIT;
      end
      S_MULSS: state_nxt = S_MULCC;
      S_MULCC: state_nxt = S_MULCT;
      S_MULCT: state_nxt = S_SUM;
      S_SUM:   state_nxt = S_SQ;
      S_SQ:    state_nxt = S_RINIT;
      S_RINIT: state_nxt = S_ROOT;
      S_ROOT:  if (cnt_r == '1) state_nxt = S_VINIT;
      S_VINIT: state_nxt = S_VEC;
      S_VEC:   if (cnt_r == IDX_W'(CORDIC_STEPS - 1)) state_nxt = S_SCALE;
      S_SCALE: state_nxt = S_FIN;
      S_FIN:   if (fin_go) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  assign in_ch.ready = (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      trig_r      <= '0;
      dlim_r      <= '0;
      tol_r       <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      sel_r       <= '0;
      cnt_r       <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        case (cfg_index)
          REG_TRIGGER:   trig_r <= cfg_wdata[MAG_W-1:0];
          REG_DISTANCE:  dlim_r <= cfg_wdata;
          REG_TOLERANCE: tol_r  <= cfg_wdata[MAG_W-1:0];
          default: ;
        endcase
      end
      if (state_r == S_FIN && fin_go) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: sel_r <= '0;
        S_INIT: cnt_r <= '0;
        S_ROT: begin
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == IDX_W'(CORDIC_STEPS - 1)) sel_r <= sel_r + 1'b1;
        end
        S_RINIT: cnt_r <= '0;
        S_ROOT:  cnt_r <= cnt_r + 1'b1;
        S_VINIT: cnt_r <= '0;
        S_VEC:   cnt_r <= cnt_r + 1'b1;
        S_FIN: begin
          if (fin_go) count_r <= last_r ? '0 : total;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          la1_r   <= in_ch.own_latitude;
          lo1_r   <= in_ch.own_longitude;
          m1_r    <= in_ch.own_magnitude;
          la2_r   <= in_ch.neighbour_latitude;
          lo2_r   <= in_ch.neighbour_longitude;
          m2_r    <= in_ch.neighbour_magnitude;
          ntrig_r <= in_ch.neighbour_triggered;
          last_r  <= in_ch.last_neighbour;
        end
      end
      S_INIT: begin
        cur_r.x <= XY_W'(CORDIC_GAIN);
        cur_r.y <= '0;
        cur_r.z <= {r4[19:0], 6'b0};
        neg_r   <= fold;
      end
      S_ROT: begin
        cur_r <= cstep;
        if (cnt_r == IDX_W'(CORDIC_STEPS - 1)) begin
          case (sel_r)
            2'd0: begin
              s1_r <= ynew;
              c1_r <= xnew;
            end
            2'd1: begin
              s2_r <= ynew;
              c2_r <= xnew;
            end
            default: ct_r <= xnew;
          endcase
        end
      end
      S_MULSS: prod_r <= mul_p;
      S_MULCC: begin
        acc_r  <= prod_r[63:30];
        prod_r <= mul_p;
      end
      S_MULCT: prod_r <= mul_p;
      S_SUM: begin
        // clamp to [-1, 1] in Q30
        if (dsum > 35'sd1073741824) d_r <= 32'sd1073741824;
        else if (dsum < -35'sd1073741824) d_r <= -32'sd1073741824;
        else d_r <= dsum[31:0];
      end
      S_SQ: prod_r <= mul_p;
      S_RINIT: begin
        n_r   <= (64'd1 << 60) - prod_r;
        res_r <= '0;
      end
      S_ROOT: begin
        if (n_r >= trial) begin
          n_r   <= n_r - trial;
          res_r <= (res_r >> 1) + bitv;
        end else begin
          res_r <= res_r >> 1;
        end
      end
      S_VINIT: begin
        if (!d_r[31]) begin
          cur_r.x <= XY_W'(d_r);
          cur_r.y <= XY_W'(res_r[31:0]);
          cur_r.z <= '0;
        end else begin
          cur_r.x <= XY_W'(res_r[31:0]);
          cur_r.y <= -XY_W'(d_r);
          cur_r.z <= Z_W'(90 * 65536);
        end
      end
      S_VEC:   cur_r  <= cstep;
      S_SCALE: prod_r <= mul_p;
      S_FIN: begin
        if (fin_go) begin
          out_match_r  <= match;
          out_total_r  <= total;
          out_report_r <= last_r && (m1_r > trig_r) &&
                          (4'(total) >= 4'(REPORT_MIN_MATCHES));
          out_done_r   <= last_r;
        end
      end
      default: ;
    endcase
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.pair_matches = out_match_r;
  assign out_ch.match_total  = out_total_r;
  assign out_ch.report_event = out_report_r;
  assign out_ch.group_done   = out_done_r;

endmodule

FILE: test/tb.sv
`timescale 1ns / 1ps
module tb;
  import nrmc_pkg::*;

  typedef struct packed {
    logic signed [LAT_W-1:0] own_lat;
    logic signed [LON_W-1:0] own_lon;
    logic [MAG_W-1:0]        own_mag;
    logic signed [LAT_W-1:0] nb_lat;
    logic signed [LON_W-1:0] nb_lon;
    logic [MAG_W-1:0]        nb_mag;
    logic                    nb_trig;
    logic                    last;
  } reading_t;

  typedef struct packed {
    logic             pair_matches;
    logic [CNT_W-1:0] match_total;
    logic             report_event;
    logic             group_done;
  } verdict_t;

  typedef struct {
    reading_t rd;
    bit       typed;
    verdict_t want;
  } dir_row_t;

  localparam int DIR_CFG_ROW = 9;
  localparam int IDLE_NONE = 0, IDLE_SEND = 1, IDLE_RECV = 2, IDLE_BOTH = 3;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [1:0]           cfg_index = REG_TRIGGER;
  logic [DIST_W-1:0]    cfg_wdata = '0;

  nrmc_in_if  in_ch ();
  nrmc_out_if out_ch ();

  neighbour_reading_match_counter dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.own_latitude = '0;
    in_ch.own_longitude = '0;
    in_ch.own_magnitude = '0;
    in_ch.neighbour_latitude = '0;
    in_ch.neighbour_longitude = '0;
    in_ch.neighbour_magnitude = '0;
    in_ch.neighbour_triggered = 1'b0;
    in_ch.last_neighbour = 1'b0;
    out_ch.ready = 1'b0;
  end

  // predictor state
  int unsigned trig_mag, dist_lim, mag_tol, group_matches;
  verdict_t    verdicts_due[$];
  int          errors;
  int          idle_mode;

  localparam longint ATAN16[16] = '{2949120, 1740967, 919879, 466945, 234379, 117304,
                                    58666, 29335, 14668, 7334, 3667, 1833, 917, 458,
                                    229, 115};

  function automatic longint unsigned root64(longint unsigned n);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic void rotate(input longint a, output longint s, output longint c);
    longint r, x, y, z, dx, dy;
    bit flip;
    r = a % FULL_TURN;
    flip = 0;
    if (r < 0) r += FULL_TURN;
    if (r > HALF_TURN) r -= FULL_TURN;
    if (r > QUARTER_TURN) begin
      r -= HALF_TURN;
      flip = 1;
    end else if (r < -QUARTER_TURN) begin
      r += HALF_TURN;
      flip = 1;
    end
    x = CORDIC_GAIN;
    y = 0;
    z = r * 64;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= ATAN16[i];
      end else begin
        x += dx; y -= dy; z += ATAN16[i];
      end
    end
    s = flip ? -y : y;
    c = flip ? -x : x;
  endfunction

  function automatic longint arc_angle(longint d);
    longint x, y, z, dx, dy, s;
    s = longint'(root64(64'd1 << 60) == 0 ? 0 : root64((64'd1 << 60) - d * d));
    if (d >= 0) begin
      x = d; y = s; z = 0;
    end else begin
      x = s; y = -d; z = 90 * 65536;
    end
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx; y -= dy; z += ATAN16[i];
      end else begin
        x -= dx; y += dy; z -= ATAN16[i];
      end
    end
    return z < 0 ? 0 : z;
  endfunction

  function automatic longint km16_between(longint la1, longint lo1, longint la2, longint lo2);
    longint s1, c1, s2, c2, st, ct, d;
    if (la1 == la2 && lo1 == lo2) return 0;
    rotate(la1, s1, c1);
    rotate(la2, s2, c2);
    rotate(lo1 - lo2, st, ct);
    d = ((s1 * s2) >>> 30) + ((((c1 * c2) >>> 30) * ct) >>> 30);
    if (d > (64'sd1 <<< 30)) d = 64'sd1 <<< 30;
    if (d < -(64'sd1 <<< 30)) d = -(64'sd1 <<< 30);
    return (arc_angle(d) * KM16_PER_DEG + (64'sd1 <<< 27)) >>> 28;
  endfunction

  function automatic verdict_t score_pair(reading_t r);
    verdict_t v;
    int unsigned diff;
    longint lat1, lon1, lat2, lon2;
    bit hit;
    hit = 0;
    if (r.nb_trig) begin
      lat1 = r.own_lat; lon1 = r.own_lon; lat2 = r.nb_lat; lon2 = r.nb_lon;
      diff = (r.own_mag > r.nb_mag) ? r.own_mag - r.nb_mag : r.nb_mag - r.own_mag;
      hit = (km16_between(lat1, lon1, lat2, lon2) < longint'(dist_lim)) && (diff < mag_tol);
    end
    if (hit && group_matches < COUNT_CAP) group_matches++;
    v.pair_matches = hit;
    v.match_total = group_matches[CNT_W-1:0];
    v.report_event = 1'b0;
    v.group_done = r.last;
    if (r.last) begin
      v.report_event = (r.own_mag > trig_mag) && (group_matches >= REPORT_MIN_MATCHES);
      group_matches = 0;
    end
    return v;
  endfunction

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $time, what);
    errors++;
  endtask

  // result side: check on handshake, then pick ready for the next cycle
  always @(posedge clk) begin
    verdict_t got, want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = '{out_ch.pair_matches, out_ch.match_total, out_ch.report_event,
              out_ch.group_done};
      if (verdicts_due.size() == 0) begin
        report_mismatch("result with nothing expected");
      end else begin
        want = verdicts_due.pop_front();
        if (got.pair_matches !== want.pair_matches)
          report_mismatch($sformatf("pair_matches %b want %b", got.pair_matches,
                                    want.pair_matches));
        if (got.match_total !== want.match_total)
          report_mismatch($sformatf("match_total %0d want %0d", got.match_total,
                                    want.match_total));
        if (got.report_event !== want.report_event)
          report_mismatch($sformatf("report_event %b want %b", got.report_event,
                                    want.report_event));
        if (got.group_done !== want.group_done)
          report_mismatch($sformatf("group_done %b want %b", got.group_done,
                                    want.group_done));
      end
    end
    case (idle_mode)
      IDLE_RECV: out_ch.ready <= ($urandom_range(99) >= 71);
      IDLE_BOTH: out_ch.ready <= ($urandom_range(99) >= 7);
      default:   out_ch.ready <= 1'b1;
    endcase
  end

  task automatic push_item(input reading_t r, input bit typed, input verdict_t want);
    verdict_t v;
    while ((idle_mode == IDLE_SEND && $urandom_range(99) < 71) ||
           (idle_mode == IDLE_BOTH && $urandom_range(99) < 7)) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.own_latitude <= r.own_lat;
    in_ch.own_longitude <= r.own_lon;
    in_ch.own_magnitude <= r.own_mag;
    in_ch.neighbour_latitude <= r.nb_lat;
    in_ch.neighbour_longitude <= r.nb_lon;
    in_ch.neighbour_magnitude <= r.nb_mag;
    in_ch.neighbour_triggered <= r.nb_trig;
    in_ch.last_neighbour <= r.last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    v = score_pair(r);
    verdicts_due.push_back(typed ? want : v);
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    while (verdicts_due.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  task automatic set_regs(input int unsigned tm, input int unsigned dl, input int unsigned tol);
    cfg_we <= 1'b1;
    cfg_index <= REG_TRIGGER;
    cfg_wdata <= DIST_W'(tm);
    @(posedge clk);
    cfg_index <= REG_DISTANCE;
    cfg_wdata <= DIST_W'(dl);
    @(posedge clk);
    cfg_index <= REG_TOLERANCE;
    cfg_wdata <= DIST_W'(tol);
    @(posedge clk);
    cfg_we <= 1'b0;
    trig_mag = tm & 12'hFFF;
    dist_lim = dl;
    mag_tol = tol & 12'hFFF;
  endtask

  function automatic reading_t make_rd(int la1, int lo1, int m1, int la2, int lo2, int m2,
                                        bit trig, bit last);
    reading_t r;
    r.own_lat = LAT_W'(la1); r.own_lon = LON_W'(lo1); r.own_mag = MAG_W'(m1);
    r.nb_lat = LAT_W'(la2); r.nb_lon = LON_W'(lo2); r.nb_mag = MAG_W'(m2);
    r.nb_trig = trig; r.last = last;
    return r;
  endfunction

  function automatic int near(int v, int span, int lo, int hi);
    int n;
    n = v + $urandom_range(2 * span) - span;
    return n < lo ? lo : (n > hi ? hi : n);
  endfunction

  // random group: well-formed groups of one own reading, with some noise
  task automatic random_group(output int n_items);
    reading_t r;
    int la, lo, m, len, pick;
    len = $urandom_range(1, 6);
    if ($urandom_range(9) == 0) begin
      la = $signed(LAT_W'($urandom)); lo = $signed(LON_W'($urandom)); m = $urandom_range(4095);
    end else begin
      la = $urandom_range(184320) - 92160; lo = $urandom_range(368640) - 184320;
      m = $urandom_range(2560);
    end
    for (int k = 0; k < len; k++) begin
      r.own_lat = LAT_W'(la); r.own_lon = LON_W'(lo); r.own_mag = MAG_W'(m);
      pick = $urandom_range(99);
      if (pick < 60) begin
        r.nb_lat = LAT_W'(near(la, 3000, -131072, 131071));
        r.nb_lon = LON_W'(near(lo, 3000, -262144, 262143));
      end else if (pick < 72) begin
        r.nb_lat = LAT_W'(la); r.nb_lon = LON_W'(lo);
      end else if (pick < 90) begin
        r.nb_lat = LAT_W'($urandom_range(184320) - 92160);
        r.nb_lon = LON_W'($urandom_range(368640) - 184320);
      end else begin
        r.nb_lat = LAT_W'($urandom); r.nb_lon = LON_W'($urandom);
      end
      r.nb_mag = MAG_W'(($urandom_range(9) == 0) ? $urandom_range(4095) : near(m, 300, 0, 4095));
      r.nb_trig = ($urandom_range(99) < 80);
      r.last = (k == len - 1) || ($urandom_range(49) == 0);
      push_item(r, 1'b0, '0);
    end
    n_items = len;
  endtask

  initial begin
    dir_row_t rows[$];
    int unsigned settings[6][3];
    int sent;
    int n;
    settings = '{'{256, 4800, 200}, '{0, 320640, 2560}, '{2560, 0, 0},
                 '{4095, 524287, 4095}, '{512, 16000, 64}, '{1, 800, 1}};
    errors = 0;
    idle_mode = IDLE_NONE;
    trig_mag = 0; dist_lim = 0; mag_tol = 0; group_matches = 0;

    // at reset values nothing can match, so these are known outright
    rows.push_back('{make_rd(-92160, -184320, 0, 92160, 184320, 2560, 1, 0), 1, 4'b0000});
    rows.push_back('{make_rd(92160, 184320, 2560, 92160, 184320, 2560, 1, 0), 1, 4'b0000});
    rows.push_back('{make_rd(0, 0, 4095, 0, 0, 4095, 0, 1), 1, 4'b0001});
    rows.push_back('{make_rd(-131072, -262144, 4095, 131071, 262143, 0, 1, 1), 1, 4'b0001});
    rows.push_back('{make_rd(131071, 262143, 0, -131072, -262144, 4095, 0, 0), 1, 4'b0000});
    rows.push_back('{make_rd(-1, -1, 2048, -1, -1, 2047, 1, 1), 1, 4'b0001});
    rows.push_back('{make_rd(43690, 87381, 2730, -43691, -87382, 1365, 1, 1), 1, 4'b0001});
    rows.push_back('{make_rd(1000, 2000, 100, 1000, 2000, 100, 1, 0), 1, 4'b0000});
    rows.push_back('{make_rd(1000, 2000, 100, 1001, 2000, 100, 1, 1), 1, 4'b0001});
    // from here on the registers are set and the predictor decides
    rows.push_back('{make_rd(5000, 5000, 600, 5000, 5000, 600, 1, 0), 0, '0});
    rows.push_back('{make_rd(5000, 5000, 600, 5010, 4990, 610, 1, 0), 0, '0});
    rows.push_back('{make_rd(5000, 5000, 600, 5000, 5000, 600, 0, 0), 0, '0});
    rows.push_back('{make_rd(5000, 5000, 600, 5000, 5000, 600, 1, 0), 0, '0});
    rows.push_back('{make_rd(5000, 5000, 600, 5000, 5000, 600, 1, 0), 0, '0});
    rows.push_back('{make_rd(5000, 5000, 600, 5000, 5000, 600, 1, 1), 0, '0});
    rows.push_back('{make_rd(92160, 0, 256, -92160, 0, 256, 1, 0), 0, '0});
    rows.push_back('{make_rd(0, 0, 256, 0, 184320, 256, 1, 0), 0, '0});
    rows.push_back('{make_rd(0, 0, 256, 10, 0, 256, 1, 1), 0, '0});
    rows.push_back('{make_rd(0, 184000, 300, 0, -184000, 300, 1, 0), 0, '0});
    rows.push_back('{make_rd(131071, 262143, 300, 131000, 262000, 300, 1, 1), 0, '0});
    rows.push_back('{make_rd(0, 0, 0, 0, 0, 0, 1, 0), 0, '0});
    rows.push_back('{make_rd(0, 0, 0, 0, 0, 0, 1, 1), 0, '0});

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[i]) begin
      if (i == DIR_CFG_ROW) begin
        settle();
        set_regs(256, 320640, 2560);
      end
      push_item(rows[i].rd, rows[i].typed, rows[i].want);
    end

    for (int p = 0; p < 8; p++) begin
      settle();
      set_regs(settings[p % 6][0], settings[p % 6][1], settings[p % 6][2]);
      idle_mode = p % 4;
      sent = 0;
      while (sent < 160) begin
        random_group(n);
        sent = sent + n;
      end
    end

    idle_mode = IDLE_NONE;
    settle();
    if (errors == 0) begin
      $display("** neighbour_reading_match_counter: PASSED **");
    end else begin
      $display("** neighbour_reading_match_counter: FAILED **");
    end
    $finish;
  end

  initial begin
    #6000000;
    $display("timeout at %0t", $time);
    $display("** neighbour_reading_match_counter: FAILED **");
    $finish;
  end

endmodule

FILE: files.f
sv/nrmc_pkg.sv
sv/nrmc_if.sv
sv/nrmc_cordic.sv
sv/neighbour_reading_match_counter.sv
test/tb.sv
